>>> rtl/core/sorted_insert_stack_defines.svh
// ---------------------------------------------------------------------------
// sorted_insert_stack_defines: assertion macros
// Shared concurrent assertion forms for the sorted insert stack.
// ---------------------------------------------------------------------------
`ifndef SORTED_INSERT_STACK_DEFINES_SVH
`define SORTED_INSERT_STACK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SIS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sorted_insert_stack: check failed");

// next-cycle implication, checked out of reset
`define SIS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sorted_insert_stack: check failed");

`endif

>>> rtl/core/sis_pkg.sv
// ---------------------------------------------------------------------------
// sis_pkg: sorted insert stack package
// Widths, defaults, status codes and cell control type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sis_pkg;

  // default sizing
  localparam int DepthDef = 64;
  localparam int DataWDef = 32;

  // fixed field widths
  localparam int CapW    = 7;
  localparam int StatusW = 2;
  localparam int FillW   = 7;

  // capacity after reset
  localparam logic [CapW-1:0] CapReset = 7'd64;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } sis_status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } sis_ctrl_t;

endpackage

>>> rtl/core/sorted_insert_stack.sv
// ---------------------------------------------------------------------------
// sorted_insert_stack: sorted max priority queue
// Push inserts a signed value in order, pop returns the largest entry.
// ---------------------------------------------------------------------------
// One request is taken per clock while s_axis_tready is high. Slot 0 of a row
// of DEPTH cells always holds the largest entry; on a push every cell compares
// its entry to the new value at once and the smaller entries move one slot
// along, on a pop every entry moves one slot toward slot 0. Each cell's
// compare and shift set that rate. Each request gives one result in the result
// register the cycle after it is taken; s_axis_tready drops only while that
// result waits and m_axis_tready is low. A push at the capacity gives status
// overflow, a pop on an empty queue gives status underflow and value zero.
// Capacity is written on the cfg channel, saturates at DEPTH, resets to 64.
`timescale 1ns / 1ps
`include "sorted_insert_stack_defines.svh"

module sorted_insert_stack import sis_pkg::*; #(
  parameter int DEPTH      = DepthDef,
  parameter int DATA_WIDTH = DataWDef,
  localparam int InW  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OutW = ((DATA_WIDTH + StatusW + FillW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration: capacity
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i,
  // request stream
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // value
  input  logic            s_axis_tuser,   // func
  // result stream
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // popped_value, status, fill_level
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > CapW) ? CntW : CapW;
  localparam logic [CntW-1:0] FillOne = CntW'(1);
  localparam logic [CmpW-1:0] DepthC  = CmpW'(DEPTH);

  logic [CapW-1:0]       cap_q;
  logic [CntW-1:0]       fill_q, fill_d;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] popped_q, popped_d;
  sis_status_e           status_q, status_d;
  logic [FillW-1:0]      level_q;

  logic                  accept, is_pop, full, empty;
  logic [CmpW-1:0]       cap_ext, eff_cap;
  sis_ctrl_t             ctrl;
  logic [DATA_WIDTH-1:0] value;
  logic [DATA_WIDTH-1:0] entry [DEPTH];
  logic                  gt    [DEPTH];

  // capacity register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // request decode
  assign value         = s_axis_tdata[DATA_WIDTH-1:0];
  assign is_pop        = s_axis_tuser;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // full and empty checks
  assign cap_ext = CmpW'(cap_q);
  assign eff_cap = (cap_ext > DepthC) ? DepthC : cap_ext;
  assign full    = CmpW'(fill_q) >= eff_cap;
  assign empty   = (fill_q == '0);

  assign ctrl.push = accept && !is_pop && !full;
  assign ctrl.pop  = accept && is_pop && !empty;

  // row of cells, slot 0 holds the largest entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic [DATA_WIDTH-1:0] lower_entry, upper_entry;
    logic                  lower_gt;

    if (i == 0) begin : g_first
      assign lower_entry = value;
      assign lower_gt    = 1'b1;
    end else begin : g_mid
      assign lower_entry = entry[i-1];
      assign lower_gt    = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_entry = entry[i];
    end else begin : g_inner
      assign upper_entry = entry[i+1];
    end

    sis_cell #(
      .DataW(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .value_i      (value),
      .occ_i        (Idx < fill_q),
      .lower_entry_i(lower_entry),
      .lower_gt_i   (lower_gt),
      .upper_entry_i(upper_entry),
      .entry_o      (entry[i]),
      .gt_o         (gt[i])
    );
  end

  // fill count and result fields
  always_comb begin
    fill_d   = fill_q;
    popped_d = '0;
    status_d = ST_OK;
    if (is_pop) begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else begin
        fill_d   = fill_q - FillOne;
        popped_d = entry[0];
      end
    end else begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else begin
        fill_d = fill_q + FillOne;
      end
    end
  end

  // fill counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
      level_q  <= FillW'(CmpW'(fill_d));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({level_q, status_q, popped_q});

  // checks
  `SIS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CntW'(DEPTH))
  `SIS_ASSERT_NEXT(a_push_grows, ctrl.push, fill_q == $past(fill_q) + FillOne)
  `SIS_ASSERT_NEXT(a_result_follows, accept, m_axis_tvalid)
  `SIS_ASSERT_NOW(a_underflow_zero, m_axis_tvalid && (status_q == ST_UNDERFLOW),
                  popped_q == '0)

endmodule

>>> rtl/core/sis_cell.sv
// ---------------------------------------------------------------------------
// sis_cell: one slot of the sorted chain
// Holds one entry, compares it to the pushed value and shifts with neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sis_cell import sis_pkg::*; #(
  parameter int DataW = DataWDef
) (
  input  logic             clk_i,
  input  sis_ctrl_t        ctrl_i,
  input  logic [DataW-1:0] value_i,
  input  logic             occ_i,
  input  logic [DataW-1:0] lower_entry_i,
  input  logic             lower_gt_i,
  input  logic [DataW-1:0] upper_entry_i,
  output logic [DataW-1:0] entry_o,
  output logic             gt_o
);

  logic [DataW-1:0] entry_q, entry_d;

  // slot holds a live entry larger than the pushed value
  assign gt_o = occ_i && ($signed(entry_q) > $signed(value_i));

  // insert: keep larger, take value at the boundary, else shift from the lower slot
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (gt_o) begin
        entry_d = entry_q;
      end else if (lower_gt_i) begin
        entry_d = value_i;
      end else begin
        entry_d = lower_entry_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = upper_entry_i;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
